[hdl/fwe_pkg.sv]
// ----------------------------------------------------------------------------
// fwe_pkg
// Shared types and constants for the filename wildcard expander: the parse
// phase encoding, the character codes the parser looks for, and the frame
// that carries one finished drive/name/type result from front to back.
// ----------------------------------------------------------------------------
package fwe_pkg;

  // Field geometry.
  localparam logic [3:0] NAME_LEN  = 4'd8;
  localparam logic [3:0] TYPE_LEN  = 4'd3;
  localparam int         FIELD_LEN = 11;
  localparam logic [3:0] LAST_IDX  = 4'd11;

  // Depth of the frame queue between parser and serializer.
  localparam int QDEPTH = 2;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSLSH = 8'h5C;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UP    = 8'h50;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  // Parser phases: the prefix phases hold one character of lookahead.
  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_ONE   = 3'd1,
    PH_DRV0  = 3'd2,
    PH_DRV1  = 3'd3,
    PH_AD0   = 3'd4,
    PH_AD1   = 3'd5,
    PH_NAME  = 3'd6,
    PH_TYPE  = 3'd7
  } phase_t;

  // One finished pattern: error flag, drive code, name bytes then type bytes.
  typedef struct packed {
    logic                      bad;
    logic [4:0]                drive;
    logic [FIELD_LEN-1:0][7:0] bytes;
  } frame_t;

endpackage

[hdl/fwe_front.sv]
// ----------------------------------------------------------------------------
// fwe_front
// Pattern parser. Accepts one character per cycle unless q_full, strips leading
// dot prefixes, decodes the drive letter and fills the name and type fields.
// On the terminator it pushes a finished frame and returns to its start state.
// ----------------------------------------------------------------------------
module fwe_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            ch_valid,
  input  logic [7:0]      ch,
  input  logic            end_of_pattern,
  input  logic            q_full,
  output logic            ch_ready,
  output logic            push,
  output fwe_pkg::frame_t push_frame
);
  import fwe_pkg::*;

  typedef struct packed {
    phase_t               phase;
    logic [7:0]           held;
    logic [7:0][7:0]      name;
    logic [2:0][7:0]      typ;
    logic [3:0]           pos;
    logic [4:0]           drive;
    logic                 err;
    logic                 ended;
  } parse_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= CH_LA && c <= CH_LZ) begin
      return c - CASE_BIT;
    end
    return c;
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SLASH) || (c == CH_BSLSH);
  endfunction

  function automatic parse_t parse_init();
    parse_t s;
    s.phase = PH_START;
    s.held  = CH_NUL;
    for (int i = 0; i < 8; i++) begin
      s.name[i] = CH_SPACE;
    end
    for (int i = 0; i < 3; i++) begin
      s.typ[i] = CH_SPACE;
    end
    s.pos   = '0;
    s.drive = '0;
    s.err   = 1'b0;
    s.ended = 1'b0;
    return s;
  endfunction

  function automatic parse_t take_drive(input parse_t si, input logic [7:0] c);
    parse_t     s;
    logic [7:0] d;
    s = si;
    d = upcase(c);
    if (d < CH_UA || d > CH_UP) begin
      s.err = 1'b1;
    end else begin
      s.drive = 5'(d - CH_UA + 8'd1);
    end
    s.phase = PH_AD0;
    return s;
  endfunction

  // One character of the name or type field.
  function automatic parse_t body_char(input parse_t si, input logic [7:0] c);
    parse_t s;
    s = si;
    if (s.phase == PH_NAME) begin
      if (c == CH_DOT) begin
        s.phase = PH_TYPE;
        s.pos   = '0;
      end else if (c == CH_STAR) begin
        for (int i = 0; i < 8; i++) begin
          if (4'(i) >= s.pos) s.name[i] = CH_QUEST;
        end
        s.pos = NAME_LEN;
      end else if (s.pos < NAME_LEN) begin
        s.name[s.pos[2:0]] = upcase(c);
        s.pos = s.pos + 4'd1;
      end
    end else begin
      if (c == CH_STAR) begin
        for (int i = 0; i < 3; i++) begin
          if (4'(i) >= s.pos) s.typ[i] = CH_QUEST;
        end
        if (s.pos < TYPE_LEN) s.pos = TYPE_LEN;
      end else if (s.pos < TYPE_LEN) begin
        s.typ[s.pos[1:0]] = upcase(c);
        s.pos = s.pos + 4'd1;
      end
    end
    return s;
  endfunction

  function automatic parse_t enter_body(input parse_t si, input logic [7:0] c0,
                                        input logic [7:0] c1, input logic two);
    parse_t s;
    s = si;
    s.phase = PH_NAME;
    s.pos   = '0;
    s = body_char(s, c0);
    if (two) s = body_char(s, c1);
    return s;
  endfunction

  function automatic parse_t fill_all(input parse_t si);
    parse_t s;
    s = si;
    for (int i = 0; i < 8; i++) begin
      s.name[i] = CH_QUEST;
    end
    for (int i = 0; i < 3; i++) begin
      s.typ[i] = CH_QUEST;
    end
    return s;
  endfunction

  parse_t st_r, st_nxt, fin;
  logic   acc;

  assign ch_ready = !q_full;
  assign acc      = ch_valid && ch_ready;

  // Closing of the pattern: resolve whatever lookahead is still held.
  always_comb begin
    fin = st_r;
    if (!st_r.err) begin
      unique case (st_r.phase)
        PH_START, PH_DRV0, PH_AD0: fin = fill_all(st_r);
        PH_ONE: begin
          if (st_r.held == CH_DOT || is_sep(st_r.held)) fin = fill_all(st_r);
          else fin = enter_body(st_r, st_r.held, CH_NUL, 1'b0);
        end
        PH_DRV1, PH_AD1: begin
          if (is_sep(st_r.held)) fin = fill_all(st_r);
          else fin = enter_body(st_r, st_r.held, CH_NUL, 1'b0);
        end
        default: fin = st_r;
      endcase
    end
  end

  // Next state of the parser for one accepted transaction.
  always_comb begin
    st_nxt = st_r;
    if (acc) begin
      if (end_of_pattern) begin
        st_nxt = parse_init();
      end else if (st_r.err || st_r.ended) begin
        st_nxt = st_r;
      end else if (ch == CH_NUL) begin
        st_nxt.ended = 1'b1;
      end else begin
        unique case (st_r.phase)
          PH_START: begin
            st_nxt.held  = ch;
            st_nxt.phase = PH_ONE;
          end
          PH_DRV0: begin
            st_nxt.held  = ch;
            st_nxt.phase = PH_DRV1;
          end
          PH_AD0: begin
            st_nxt.held  = ch;
            st_nxt.phase = PH_AD1;
          end
          PH_ONE: begin
            if (st_r.held == CH_DOT && is_sep(ch)) st_nxt.phase = PH_DRV0;
            else if (ch == CH_COLON) st_nxt = take_drive(st_r, st_r.held);
            else st_nxt = enter_body(st_r, st_r.held, ch, 1'b1);
          end
          PH_DRV1: begin
            if (ch == CH_COLON) st_nxt = take_drive(st_r, st_r.held);
            else st_nxt = enter_body(st_r, st_r.held, ch, 1'b1);
          end
          PH_AD1: st_nxt = enter_body(st_r, st_r.held, ch, 1'b1);
          default: st_nxt = body_char(st_r, ch);
        endcase
      end
    end
  end

  // Frame handed to the queue on a terminator.
  always_comb begin
    push             = acc && end_of_pattern;
    push_frame.bad   = fin.err;
    push_frame.drive = fin.drive;
    for (int i = 0; i < 8; i++) begin
      push_frame.bytes[i] = fin.name[i];
    end
    for (int i = 0; i < 3; i++) begin
      push_frame.bytes[8 + i] = fin.typ[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= parse_init();
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

[hdl/fwe_queue.sv]
// ----------------------------------------------------------------------------
// fwe_queue
// Small frame queue between the parser and the serializer, so that the
// parser can take the next pattern while results are still going out.
// ----------------------------------------------------------------------------
module fwe_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fwe_pkg::frame_t push_frame,
  input  logic            pop,
  output fwe_pkg::frame_t head,
  output logic            full,
  output logic            empty
);
  import fwe_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  frame_t        mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full  = (count_r == CW'(QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Storage, written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_frame;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

[hdl/fwe_back.sv]
// ----------------------------------------------------------------------------
// fwe_back
// Result serializer. Loads one frame at a time and sends the drive byte and
// the eleven field bytes, or a single error result, one per res_ready cycle.
// ----------------------------------------------------------------------------
module fwe_back (
  input  logic            clk,
  input  logic            rst_n,
  input  fwe_pkg::frame_t head,
  input  logic            empty,
  output logic            pop,
  input  logic            res_ready,
  output logic            res_valid,
  output logic [3:0]      byte_index,
  output logic [7:0]      byte_value,
  output logic            bad_pattern,
  output logic            last
);
  import fwe_pkg::*;

  frame_t     frame_r;
  logic       busy_r;
  logic [3:0] idx_r;
  logic       fire, done;

  assign res_valid = busy_r;
  assign fire      = busy_r && res_ready;
  assign done      = fire && last;
  assign pop       = (!busy_r || done) && !empty;

  // Result fields from the current frame and byte counter.
  always_comb begin
    byte_index  = idx_r;
    bad_pattern = frame_r.bad;
    last        = frame_r.bad || (idx_r == LAST_IDX);
    if (frame_r.bad) begin
      byte_value = '0;
    end else if (idx_r == '0) begin
      byte_value = {3'b000, frame_r.drive};
    end else begin
      byte_value = frame_r.bytes[idx_r - 4'd1];
    end
  end

  // Frame payload, loaded as the queue head is taken.
  always_ff @(posedge clk) begin
    if (pop) begin
      frame_r <= head;
    end
  end

  // Serializer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (done) begin
        busy_r <= 1'b0;
        idx_r  <= '0;
      end else if (fire) begin
        idx_r <= idx_r + 4'd1;
      end
    end
  end

endmodule

[hdl/filename_wildcard_expander.sv]
// ----------------------------------------------------------------------------
// filename_wildcard_expander
// Expands a wildcard filename pattern into a drive code plus the eight name
// and three type bytes of a directory search block.
// ----------------------------------------------------------------------------
//  Channel | Direction | Transaction contents
//  in_*    | slave     | tdata: ch[7:0]; tlast: end_of_pattern
//  out_*   | master    | tdata: byte_index[3:0], byte_value[11:4], zeros[15:12];
//          |           | tuser: bad_pattern; tlast: last
//
// The parser takes one character per cycle with no bubbles unless stalled;
// a terminator turns into a frame in a two-entry queue. The serializer
// sends one result per cycle while out_tready is high, twelve per pattern
// (one for a bad drive), so the output side sets the sustained rate for
// short patterns. in_tready drops only while both queue entries hold frames.
// Reset (rst_n low, synchronous) empties the queue and restarts the parser.
// ----------------------------------------------------------------------------
module filename_wildcard_expander (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] byte_index, [11:4] byte_value
  output logic        out_tuser,  // [0] bad_pattern
  output logic        out_tlast
);
  import fwe_pkg::*;

  frame_t     push_frame, head;
  logic       push, pop, q_full, q_empty;
  logic [3:0] byte_index;
  logic [7:0] byte_value;

  fwe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .ch_valid       (in_tvalid),
    .ch             (in_tdata),
    .end_of_pattern (in_tlast),
    .q_full         (q_full),
    .ch_ready       (in_tready),
    .push           (push),
    .push_frame     (push_frame)
  );

  fwe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  fwe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .empty       (q_empty),
    .pop         (pop),
    .res_ready   (out_tready),
    .res_valid   (out_tvalid),
    .byte_index  (byte_index),
    .byte_value  (byte_value),
    .bad_pattern (out_tuser),
    .last        (out_tlast)
  );

  // Pack the result fields, lowest field first.
  assign out_tdata = {4'b0000, byte_value, byte_index};

endmodule

[dv/fwe_result_checker.sv]
// ----------------------------------------------------------------------------
// fwe_result_checker
// Watches both streams of the filename wildcard expander, keeps its own
// model of the pattern parser, and compares every result transaction with
// the bytes the model says a finished pattern must produce.
// ----------------------------------------------------------------------------
module fwe_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,        // [7:0] ch
  input  logic        in_tlast,        // end_of_pattern
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,       // [3:0] byte_index, [11:4] byte_value
  input  logic        out_tuser,       // [0] bad_pattern
  input  logic        out_tlast,       // last
  output logic [31:0] mismatch_count,
  output logic [31:0] pending_count,
  output logic [31:0] compared_count
);

  timeunit 1ns;
  timeprecision 1ps;

  import fwe_pkg::*;

  // One expected result transaction.
  typedef struct packed {
    logic [3:0] idx;
    logic [7:0] val;
    logic       bad;
    logic       last;
  } search_byte_t;

  search_byte_t expected_bytes[$];
  search_byte_t want;

  // Parser state of the model.
  phase_t     phase;
  logic [7:0] held;
  logic [7:0] name_buf [0:NAME_LEN-1];
  logic [7:0] type_buf [0:TYPE_LEN-1];
  logic [3:0] fpos;
  logic [4:0] drv;
  logic       bad_seen;
  logic       text_done;

  int errors   = 0;
  int compared = 0;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= CH_LA && c <= CH_LZ) return c - CASE_BIT;
    return c;
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return c == CH_SLASH || c == CH_BSLSH;
  endfunction

  task automatic clear_pattern();
    phase     = PH_START;
    held      = CH_NUL;
    fpos      = '0;
    drv       = '0;
    bad_seen  = 1'b0;
    text_done = 1'b0;
    for (int k = 0; k < NAME_LEN; k++) name_buf[k] = CH_SPACE;
    for (int k = 0; k < TYPE_LEN; k++) type_buf[k] = CH_SPACE;
  endtask

  task automatic fill_all();
    for (int k = 0; k < NAME_LEN; k++) name_buf[k] = CH_QUEST;
    for (int k = 0; k < TYPE_LEN; k++) type_buf[k] = CH_QUEST;
  endtask

  // A drive letter outside A..P poisons the whole pattern.
  task automatic take_drive(input logic [7:0] c);
    logic [7:0] d;
    d = upcase(c);
    if (d < CH_UA || d > CH_UP) bad_seen = 1'b1;
    else drv = 5'(d - CH_UA + 8'd1);
  endtask

  // One character of the name or type field.
  task automatic body_char(input logic [7:0] c);
    if (phase == PH_NAME) begin
      if (c == CH_DOT) begin
        phase = PH_TYPE;
        fpos  = '0;
      end else if (c == CH_STAR) begin
        while (fpos < NAME_LEN) begin
          name_buf[fpos] = CH_QUEST;
          fpos++;
        end
      end else if (fpos < NAME_LEN) begin
        name_buf[fpos] = upcase(c);
        fpos++;
      end
    end else begin
      if (c == CH_STAR) begin
        while (fpos < TYPE_LEN) begin
          type_buf[fpos] = CH_QUEST;
          fpos++;
        end
      end else if (fpos < TYPE_LEN) begin
        type_buf[fpos] = upcase(c);
        fpos++;
      end
    end
  endtask

  task automatic enter_body(input logic [7:0] c0, input logic [7:0] c1, input logic two);
    phase = PH_NAME;
    fpos  = '0;
    body_char(c0);
    if (two) body_char(c1);
  endtask

  // A pattern character: prefix handling with one held character, then body.
  task automatic advance_parser(input logic [7:0] c);
    if (bad_seen || text_done) return;
    if (c == CH_NUL) begin
      text_done = 1'b1;
      return;
    end
    case (phase)
      PH_START, PH_DRV0, PH_AD0: begin
        held  = c;
        phase = phase_t'(phase + 3'd1);
      end
      PH_ONE: begin
        if (held == CH_DOT && is_sep(c)) begin
          phase = PH_DRV0;
        end else if (c == CH_COLON) begin
          take_drive(held);
          phase = PH_AD0;
        end else begin
          enter_body(held, c, 1'b1);
        end
      end
      PH_DRV1: begin
        if (c == CH_COLON) begin
          take_drive(held);
          phase = PH_AD0;
        end else begin
          enter_body(held, c, 1'b1);
        end
      end
      PH_AD1: enter_body(held, c, 1'b1);
      default: body_char(c);
    endcase
  endtask

  // Terminator: resolve the held character and queue the expected results.
  task automatic expand_pattern();
    if (!bad_seen) begin
      case (phase)
        PH_START, PH_DRV0, PH_AD0: fill_all();
        PH_ONE: begin
          if (held == CH_DOT || is_sep(held)) fill_all();
          else enter_body(held, CH_NUL, 1'b0);
        end
        PH_DRV1, PH_AD1: begin
          if (is_sep(held)) fill_all();
          else enter_body(held, CH_NUL, 1'b0);
        end
        default: ;
      endcase
    end
    if (bad_seen) begin
      expected_bytes.push_back('{idx: 4'd0, val: 8'd0, bad: 1'b1, last: 1'b1});
    end else begin
      expected_bytes.push_back('{idx: 4'd0, val: {3'd0, drv}, bad: 1'b0, last: 1'b0});
      for (int k = 0; k < NAME_LEN; k++)
        expected_bytes.push_back('{idx: 4'(k + 1), val: name_buf[k], bad: 1'b0, last: 1'b0});
      for (int k = 0; k < TYPE_LEN; k++)
        expected_bytes.push_back('{idx: 4'(k + 9), val: type_buf[k], bad: 1'b0,
                                   last: 1'(k == TYPE_LEN - 1)});
    end
    clear_pattern();
  endtask

  task automatic check_field(input string what, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h",
               $realtime, what, exp_v, got_v);
    end
  endtask

  // Transactions are taken in the order they occur at each clock edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_pattern();
      expected_bytes.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        if (in_tlast) expand_pattern();
        else advance_parser(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual index %0d value 0x%02h",
                   $realtime, out_tdata[3:0], out_tdata[11:4]);
        end else begin
          want = expected_bytes.pop_front();
          compared++;
          check_field("byte_index", {4'd0, want.idx}, {4'd0, out_tdata[3:0]});
          check_field("byte_value", want.val, out_tdata[11:4]);
          check_field("bad_pattern", {7'd0, want.bad}, {7'd0, out_tuser});
          check_field("last", {7'd0, want.last}, {7'd0, out_tlast});
        end
      end
    end
    mismatch_count <= errors;
    pending_count  <= expected_bytes.size();
    compared_count <= compared;
  end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the filename wildcard expander: sends directed and random
// filename patterns in bursts, stalls the result side on shifting patterns,
// and takes the verdict from the result checker.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import fwe_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] ch
  logic        in_tlast;    // end_of_pattern
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;   // [3:0] byte_index, [11:4] byte_value
  logic        out_tuser;   // [0] bad_pattern
  logic        out_tlast;

  logic [31:0] mismatch_count;
  logic [31:0] pending_count;
  logic [31:0] compared_count;

  int items_sent    = 0;
  int patterns_sent = 0;
  int burst_left    = 0;
  bit calm          = 1'b0;

  logic [7:0] stall_cycle = '0;
  logic [1:0] stall_mode  = '0;

  always #1 clk = ~clk;

  filename_wildcard_expander dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  fwe_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .compared_count (compared_count)
  );

  // Result side stalls: the mode is redrawn whenever stall_cycle[5:0] is zero.
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 8'd1;
    if (stall_cycle[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= 1'($urandom_range(0, 1));
      2'd2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (stall_cycle[2:0] != 3'd5);
    endcase
  end

  // One input transaction; a burst starts with a random gap unless calm is set.
  task automatic send_item(input logic [7:0] ch, input logic eop);
    int gap;
    if (burst_left == 0) begin
      gap        = calm ? 0 : $urandom_range(1, 5);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= eop;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
    patterns_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    send_end();
  endtask

  // Characters weighted toward what the parser treats specially.
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0, 1, 2: c = CH_UA + 8'($urandom_range(0, 25));
      3, 4:    c = CH_LA + 8'($urandom_range(0, 25));
      5:       c = 8'h30 + 8'($urandom_range(0, 9));
      6:       c = CH_QUEST;
      7:       c = CH_STAR;
      8:       c = CH_DOT;
      9:       c = $urandom_range(0, 1) ? CH_SLASH : CH_BSLSH;
      10:      c = CH_COLON;
      default: c = 8'($urandom_range(1, 255));
    endcase
    return c;
  endfunction

  initial begin
    logic [7:0] pat[$];
    logic [7:0] d;
    int         n;
    int         kind;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pattern and lone separator give all wildcards.
    send_text("");
    send_text("/");
    // Bad drive letter; the characters after it are ignored.
    send_text("q:x");
    // Highest drive, star in the name, dot stored inside the type field.
    send_text("p:*.t.x");
    // Dot-slash prefix stripped; a zero byte ends the text early.
    send_item(CH_DOT, 1'b0);
    send_item(CH_SLASH, 1'b0);
    send_item(CH_LA, 1'b0);
    send_item(CH_NUL, 1'b0);
    send_item(CH_LZ, 1'b0);
    send_end();
    // Top of the character range and a passed-through question mark.
    send_item(8'hFF, 1'b0);
    send_item(CH_QUEST, 1'b0);
    send_end();

    // Random patterns: mostly well formed, some noise and broken ones.
    while (items_sent < 220) begin
      pat.delete();
      calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        n = $urandom_range(0, 6);
        repeat (n) pat.push_back(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 5))
          0: pat.push_back(CH_DOT);
          1: begin pat.push_back(CH_DOT); pat.push_back(CH_SLASH); end
          2: begin pat.push_back(CH_DOT); pat.push_back(CH_BSLSH); end
          default: ;
        endcase
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 7))
            0:       d = 8'($urandom_range(1, 255));
            1:       d = CH_UP + 8'($urandom_range(1, 10));
            default: d = CH_UA + 8'($urandom_range(0, 15));
          endcase
          if ($urandom_range(0, 1) && d >= CH_UA && d <= 8'h5A) d = d | CASE_BIT;
          pat.push_back(d);
          pat.push_back(CH_COLON);
        end
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 11) : $urandom_range(0, 6);
        repeat (n) pat.push_back(pick_char());
        if ($urandom_range(0, 2) != 0) begin
          pat.push_back(CH_DOT);
          n = $urandom_range(0, 5);
          repeat (n) pat.push_back(pick_char());
        end
        // Broken sequences: a stray zero byte or a lone separator.
        if (kind == 1) pat.insert($urandom_range(0, pat.size()), CH_NUL);
        if (kind == 2) begin
          pat.delete();
          pat.push_back($urandom_range(0, 1) ? CH_SLASH : CH_BSLSH);
        end
      end
      foreach (pat[i]) send_item(pat[i], 1'b0);
      send_end();
    end

    // Drain: wait for every expected result, then for any stray ones.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d patterns in %0d input transactions.", patterns_sent, items_sent);
    $display("Compared %0d result transactions; %0d mismatches.",
             compared_count, mismatch_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #400000;
    $display("Timeout: results still outstanding");
    $display("Some tests failed");
    $finish;
  end

endmodule
